[design/tlps_pkg.sv]
// ============================================================================
// tlps_pkg
// Shared types and codes for the three-lane priority scheduler.
// ============================================================================
`default_nettype none

package tlps_pkg;

    localparam int TYPE_W  = 4;
    localparam int PRIO_W  = 4;
    localparam int CAP_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    typedef logic [1:0] lane_t;
    typedef logic [1:0] status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam lane_t LANE_CONTROL = 2'd0;
    localparam lane_t LANE_ALARM   = 2'd1;
    localparam lane_t LANE_NORMAL  = 2'd2;

    localparam status_t ST_DONE       = 2'd0;
    localparam status_t ST_PUSH_FULL  = 2'd1;
    localparam status_t ST_POP_EMPTY  = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam cfg_idx_t CFG_CHAT_TYPE   = 3'd0;
    localparam cfg_idx_t CFG_HIGH_PRIO   = 3'd1;
    localparam cfg_idx_t CFG_CONTROL_CAP = 3'd2;
    localparam cfg_idx_t CFG_ALARM_CAP   = 3'd3;
    localparam cfg_idx_t CFG_NORMAL_CAP  = 3'd4;

    localparam logic [TYPE_W-1:0] CHAT_TYPE_RST = 4'd0;
    localparam logic [PRIO_W-1:0] HIGH_PRIO_RST = 4'd2;
    localparam logic [CAP_W-1:0]  CAP_RST       = 7'd64;

    localparam logic [1:0] NSA_LIMIT = 2'd2;

endpackage

`default_nettype wire

[design/tlps_if.sv]
// ============================================================================
// tlps_if
// Channel interfaces: request, response and configuration write.
// ============================================================================
`default_nettype none

interface tlps_req_if import tlps_pkg::*; #(
    parameter int HANDLE_WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [TYPE_W-1:0]       msg_type;
    logic [PRIO_W-1:0]       priority_req;
    logic                    from_alarm_source;
    logic [HANDLE_WIDTH-1:0] message_handle;

    modport source (
        output valid, operation, msg_type, priority_req, from_alarm_source,
               message_handle,
        input  ready
    );
    modport sink (
        input  valid, operation, msg_type, priority_req, from_alarm_source,
               message_handle,
        output ready
    );
endinterface

interface tlps_rsp_if import tlps_pkg::*; #(
    parameter int HANDLE_WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    status_t                 status;
    lane_t                   lane_used;
    logic [HANDLE_WIDTH-1:0] handle_out;

    modport source (
        output valid, status, lane_used, handle_out,
        input  ready
    );
    modport sink (
        input  valid, status, lane_used, handle_out,
        output ready
    );
endinterface

interface tlps_cfg_if import tlps_pkg::*;;
    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

[design/three_lane_priority_scheduler_core.sv]
// ============================================================================
// three_lane_priority_scheduler_core
// Control / alarm / normal FIFO lanes of message handles sharing one RAM,
// with strict control priority and an alarm starvation guard.
// ============================================================================
//
//  channel  dir  payload
//  -------  ---  -----------------------------------------------------------
//  req      in   operation, msg_type, priority_req, from_alarm_source,
//                message_handle
//  rsp      out  status, lane_used, handle_out
//  cfg      in   index, data (always ready)
//
//  One request transfer per cycle while req is ready; its response appears in
//  the cycle after, as the shared handle RAM has a registered read.
//  rsp is held in an output register; req stays ready while that register
//  is empty or being drained in the same cycle.
//  rst_n clears lane pointers, counts and guard counter and sets the
//  configuration to its reset values; the handle RAM is not cleared and needs no sweep.
// ============================================================================
`default_nettype none

module three_lane_priority_scheduler_core import tlps_pkg::*; #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int HANDLE_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tlps_req_if.sink  req,
    tlps_rsp_if.source rsp,
    tlps_cfg_if.sink  cfg
);

    localparam int PW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW   = (CW > CAP_W) ? CW : CAP_W;
    localparam int AW     = PW + 2;
    localparam int RAM_D  = 3 << PW;

    typedef logic [PW-1:0] ptr_t;
    typedef logic [CW-1:0] cnt_t;

    logic [TYPE_W-1:0] chat_type_reg;
    logic [PRIO_W-1:0] high_prio_reg;
    logic [CAP_W-1:0]  cap_reg [3];

    ptr_t head_reg [3];
    ptr_t tail_reg [3];
    cnt_t count_reg [3];
    ptr_t head_next [3];
    ptr_t tail_next [3];
    cnt_t count_next [3];
    logic [1:0] nsa_reg;
    logic [1:0] nsa_next;

    logic    out_valid_reg;
    status_t out_status_reg;
    lane_t   out_lane_reg;
    logic    out_data_reg;
    status_t out_status_next;
    lane_t   out_lane_next;
    logic    out_data_next;

    logic    accept;
    lane_t   push_lane;
    logic    push_full;
    lane_t   pop_lane;
    logic    pop_any;
    logic    ram_wr_en;
    logic    ram_rd_en;
    logic [AW-1:0] ram_wr_addr;
    logic [AW-1:0] ram_rd_addr;
    logic [HANDLE_WIDTH-1:0] ram_rd_data;

    function automatic ptr_t advance(input ptr_t p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    function automatic logic lane_full(input cnt_t cnt, input logic [CAP_W-1:0] cap);
        return (CMPW'(cnt) >= CMPW'(cap)) || (cnt >= CW'(QUEUE_DEPTH));
    endfunction

    assign accept    = req.valid && req.ready;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (req.msg_type != chat_type_reg)
            push_lane = LANE_CONTROL;
        else if ((req.priority_req >= high_prio_reg) && req.from_alarm_source)
            push_lane = LANE_ALARM;
        else
            push_lane = LANE_NORMAL;
    end

    assign push_full = lane_full(count_reg[push_lane], cap_reg[push_lane]);

    always_comb
    begin
        pop_any = 1'b1;
        if (count_reg[LANE_CONTROL] != '0)
            pop_lane = LANE_CONTROL;
        else if ((count_reg[LANE_ALARM] != '0)
                 && ((count_reg[LANE_NORMAL] == '0) || (nsa_reg >= NSA_LIMIT)))
            pop_lane = LANE_ALARM;
        else if (count_reg[LANE_NORMAL] != '0)
            pop_lane = LANE_NORMAL;
        else
        begin
            pop_lane = LANE_CONTROL;
            pop_any  = 1'b0;
        end
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        nsa_next        = nsa_reg;
        out_status_next = ST_DONE;
        out_lane_next   = LANE_CONTROL;
        out_data_next   = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        if (accept)
        begin
            if (req.operation == OP_PUSH)
            begin
                out_lane_next = push_lane;
                if (push_full)
                    out_status_next = ST_PUSH_FULL;
                else
                begin
                    ram_wr_en             = 1'b1;
                    tail_next[push_lane]  = advance(tail_reg[push_lane]);
                    count_next[push_lane] = CW'(count_reg[push_lane] + 1'b1);
                end
            end
            else if (pop_any)
            begin
                out_lane_next        = pop_lane;
                out_data_next        = 1'b1;
                ram_rd_en            = 1'b1;
                head_next[pop_lane]  = advance(head_reg[pop_lane]);
                count_next[pop_lane] = CW'(count_reg[pop_lane] - 1'b1);
                if (pop_lane == LANE_ALARM)
                    nsa_next = '0;
                else if ((pop_lane == LANE_NORMAL) && (nsa_reg < NSA_LIMIT))
                    nsa_next = 2'(nsa_reg + 1'b1);
            end
            else
                out_status_next = ST_POP_EMPTY;
        end
    end

    assign ram_wr_addr = {push_lane, tail_reg[push_lane]};
    assign ram_rd_addr = {pop_lane, head_reg[pop_lane]};

    tlps_handle_ram #(
        .ADDR_W (AW),
        .DATA_W (HANDLE_WIDTH),
        .DEPTH  (RAM_D)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (req.message_handle),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chat_type_reg <= CHAT_TYPE_RST;
            high_prio_reg <= HIGH_PRIO_RST;
            for (int i = 0; i < 3; i++)
            begin
                cap_reg[i] <= CAP_RST;
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_CHAT_TYPE:   chat_type_reg <= cfg.data[TYPE_W-1:0];
                CFG_HIGH_PRIO:   high_prio_reg <= cfg.data[PRIO_W-1:0];
                CFG_CONTROL_CAP: cap_reg[LANE_CONTROL] <= cfg.data;
                CFG_ALARM_CAP:   cap_reg[LANE_ALARM]   <= cfg.data;
                CFG_NORMAL_CAP:  cap_reg[LANE_NORMAL]  <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            nsa_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_DONE;
            out_lane_reg   <= LANE_CONTROL;
            out_data_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            nsa_reg   <= nsa_next;
            if (accept)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= out_status_next;
                out_lane_reg   <= out_lane_next;
                out_data_reg   <= out_data_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.lane_used  = out_lane_reg;
    assign rsp.handle_out = out_data_reg ? ram_rd_data : '0;

endmodule

`default_nettype wire

[design/tlps_handle_ram.sv]
// ============================================================================
// tlps_handle_ram
// Single-port-write, single-port-read handle memory, registered read data.
// ============================================================================
`default_nettype none

module tlps_handle_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32,
    parameter int DEPTH  = 192
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sim/tb_three_lane_priority_scheduler_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_three_lane_priority_scheduler_core
// Self-checking bench for the three-lane priority scheduler. A clocked driver
// sends push/pop requests from a pending queue in random bursts. A scoreboard
// model predicts lane choice, full/empty status and popped handles on every
// request transfer. A clocked monitor compares each response transfer with
// the oldest prediction while stalling on random patterns and holding off
// once for a long stretch. The configuration is rewritten between phases.
// ============================================================================

module tb_three_lane_priority_scheduler_core;
    import tlps_pkg::*;

    localparam int QDEPTH      = 64;
    localparam int HANDLE_W    = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;

    localparam cfg_idx_t CFG_UNUSED_LO = 3'd5;
    localparam cfg_idx_t CFG_UNUSED_HI = 3'd7;

    typedef struct {
        logic                op;
        logic [TYPE_W-1:0]   mtype;
        logic [PRIO_W-1:0]   prio;
        logic                alarm_src;
        logic [HANDLE_W-1:0] handle;
    } sched_req_t;

    typedef struct {
        status_t             status;
        lane_t               lane;
        logic [HANDLE_W-1:0] handle;
    } sched_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    tlps_req_if #(.HANDLE_WIDTH(HANDLE_W)) req_ch ();
    tlps_rsp_if #(.HANDLE_WIDTH(HANDLE_W)) rsp_ch ();
    tlps_cfg_if cfg_ch ();

    three_lane_priority_scheduler_core #(
        .QUEUE_DEPTH  (QDEPTH),
        .HANDLE_WIDTH (HANDLE_W)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // scheduler state mirror
    logic [TYPE_W-1:0]   chat_type_reg;
    logic [PRIO_W-1:0]   high_prio_reg;
    logic [CAP_W-1:0]    lane_cap_reg [3];
    logic [HANDLE_W-1:0] lane_fifo [3][$];
    logic [1:0]          normals_since_alarm;

    sched_req_t req_pending_q [$];
    sched_rsp_t rsp_expected_q [$];

    int fail_count = 0;
    int n_push     = 0;
    int n_reject   = 0;
    int n_pop      = 0;
    int n_empty    = 0;
    int n_served [3];
    int reg_writes = 0;
    int n_settings = 0;
    logic pressure_go = 1'b0;

    function automatic sched_rsp_t schedule_step(sched_req_t it);
        sched_rsp_t  r;
        lane_t       ln;
        int unsigned room;
        r.status = ST_DONE;
        r.lane   = LANE_CONTROL;
        r.handle = '0;
        if (it.op == OP_PUSH)
        begin
            if (it.mtype != chat_type_reg)
                ln = LANE_CONTROL;
            else if (it.prio >= high_prio_reg && it.alarm_src)
                ln = LANE_ALARM;
            else
                ln = LANE_NORMAL;
            r.lane = ln;
            room = (lane_cap_reg[ln] > QDEPTH) ? QDEPTH : lane_cap_reg[ln];
            if (lane_fifo[ln].size() >= room)
                r.status = ST_PUSH_FULL;
            else
                lane_fifo[ln].push_back(it.handle);
        end
        else if (lane_fifo[LANE_CONTROL].size() != 0)
        begin
            r.lane   = LANE_CONTROL;
            r.handle = lane_fifo[LANE_CONTROL].pop_front();
        end
        else if (lane_fifo[LANE_ALARM].size() != 0 &&
                 (lane_fifo[LANE_NORMAL].size() == 0 || normals_since_alarm >= NSA_LIMIT))
        begin
            r.lane              = LANE_ALARM;
            r.handle            = lane_fifo[LANE_ALARM].pop_front();
            normals_since_alarm = '0;
        end
        else if (lane_fifo[LANE_NORMAL].size() != 0)
        begin
            r.lane   = LANE_NORMAL;
            r.handle = lane_fifo[LANE_NORMAL].pop_front();
            if (normals_since_alarm < NSA_LIMIT)
                normals_since_alarm++;
        end
        else
        begin
            r.status = ST_POP_EMPTY;
        end
        return r;
    endfunction

    // request driver
    sched_req_t cur_req;
    sched_rsp_t pred;
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                pred = schedule_step(cur_req);
                rsp_expected_q.push_back(pred);
                if (cur_req.op == OP_PUSH)
                begin
                    n_push++;
                    if (pred.status == ST_PUSH_FULL)
                        n_reject++;
                end
                else
                begin
                    n_pop++;
                    if (pred.status == ST_POP_EMPTY)
                        n_empty++;
                    else
                        n_served[pred.lane]++;
                end
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (req_pending_q.size() != 0)
                begin
                    cur_req = req_pending_q.pop_front();
                    req_ch.valid             <= 1'b1;
                    req_ch.operation         <= cur_req.op;
                    req_ch.msg_type          <= cur_req.mtype;
                    req_ch.priority_req      <= cur_req.prio;
                    req_ch.from_alarm_source <= cur_req.alarm_src;
                    req_ch.message_handle    <= cur_req.handle;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    int hold_left     = 0;
    logic hold_done   = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (pressure_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // response monitor
    sched_rsp_t exp_rsp;
    logic [15:0] stall_pat;
    int pat_left      = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_expected_q.size() == 0)
                begin
                    $error("unexpected response: status %0d lane %0d handle %h",
                           rsp_ch.status, rsp_ch.lane_used, rsp_ch.handle_out);
                    fail_count++;
                end
                else
                begin
                    exp_rsp = rsp_expected_q.pop_front();
                    if (rsp_ch.status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_rsp.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.lane_used !== exp_rsp.lane)
                    begin
                        $error("lane_used: expected %0d, got %0d",
                               exp_rsp.lane, rsp_ch.lane_used);
                        fail_count++;
                    end
                    if (rsp_ch.handle_out !== exp_rsp.handle)
                    begin
                        $error("handle_out: expected %h, got %h",
                               exp_rsp.handle, rsp_ch.handle_out);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_pat = 16'hFFFF;
                        1: stall_pat = 16'($urandom);
                        2: stall_pat = 16'($urandom) | 16'($urandom);
                        default: stall_pat = ~(16'h1 << $urandom_range(0, 15));
                    endcase
                    pat_left = 16;
                end
                rsp_ch.ready <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
                pat_left--;
            end
        end
    end

    // watchdog
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_CHAT_TYPE:   chat_type_reg = val[TYPE_W-1:0];
            CFG_HIGH_PRIO:   high_prio_reg = val[PRIO_W-1:0];
            CFG_CONTROL_CAP: lane_cap_reg[LANE_CONTROL] = val;
            CFG_ALARM_CAP:   lane_cap_reg[LANE_ALARM]   = val;
            CFG_NORMAL_CAP:  lane_cap_reg[LANE_NORMAL]  = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic add_push(logic [TYPE_W-1:0] t, logic [PRIO_W-1:0] p, logic s,
                            logic [HANDLE_W-1:0] h);
        sched_req_t it;
        it.op        = OP_PUSH;
        it.mtype     = t;
        it.prio      = p;
        it.alarm_src = s;
        it.handle    = h;
        req_pending_q.push_back(it);
    endtask

    task automatic add_pop();
        sched_req_t it;
        it.op        = OP_POP;
        it.mtype     = 4'($urandom);
        it.prio      = 4'($urandom);
        it.alarm_src = 1'($urandom);
        it.handle    = $urandom;
        req_pending_q.push_back(it);
    endtask

    task automatic add_random(int n, int push_pct, int chat_pct);
        logic [TYPE_W-1:0] t;
        logic [PRIO_W-1:0] p;
        repeat (n)
        begin
            if ($urandom_range(1, 100) <= push_pct)
            begin
                t = ($urandom_range(1, 100) <= chat_pct) ? chat_type_reg : 4'($urandom);
                p = ($urandom_range(0, 3) == 0) ? high_prio_reg : 4'($urandom);
                add_push(t, p, 1'($urandom), $urandom);
            end
            else
            begin
                add_pop();
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_pending_q.size() != 0 || req_ch.valid || rsp_expected_q.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_cap();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd64;
            2: return 7'd127;
            3: return 7'($urandom_range(65, 126));
            4: return 7'($urandom_range(1, 64));
            default: return 7'($urandom_range(1, 6));
        endcase
    endfunction

    initial
    begin
        rst_n                    = 1'b0;
        req_ch.valid             = 1'b0;
        req_ch.operation         = OP_PUSH;
        req_ch.msg_type          = '0;
        req_ch.priority_req      = '0;
        req_ch.from_alarm_source = 1'b0;
        req_ch.message_handle    = '0;
        rsp_ch.ready             = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = CFG_CHAT_TYPE;
        cfg_ch.data              = '0;
        chat_type_reg            = CHAT_TYPE_RST;
        high_prio_reg            = HIGH_PRIO_RST;
        foreach (lane_cap_reg[i])
            lane_cap_reg[i] = CAP_RST;
        foreach (n_served[i])
            n_served[i] = 0;
        normals_since_alarm = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: classification edges and the starvation guard
        n_settings++;
        add_pop();
        add_push(4'hF, 4'h0, 1'b0, 32'hFFFF_FFFF);
        add_push(4'h0, 4'hF, 1'b1, 32'h0000_0000);
        add_push(4'h0, 4'h1, 1'b1, 32'h0000_0001);
        add_push(4'h0, 4'h2, 1'b1, 32'hA5A5_A5A5);
        add_push(4'h0, 4'hF, 1'b0, 32'h5A5A_5A5A);
        add_push(4'h0, 4'h0, 1'b0, 32'h0000_0002);
        add_push(4'h3, 4'hF, 1'b1, 32'h0000_0003);
        repeat (8) add_pop();
        wait_drained();

        // extremes: zero and oversize capacity, masked data, unused indexes
        n_settings++;
        write_reg(CFG_CHAT_TYPE, 7'h7F);
        write_reg(CFG_HIGH_PRIO, 7'h70);
        write_reg(CFG_CONTROL_CAP, 7'd0);
        write_reg(CFG_ALARM_CAP, 7'd1);
        write_reg(CFG_NORMAL_CAP, 7'd127);
        write_reg(CFG_UNUSED_LO, 7'($urandom));
        write_reg(CFG_UNUSED_HI, 7'($urandom));
        add_push(4'h0, 4'hF, 1'b1, $urandom);
        add_push(4'hF, 4'h0, 1'b1, $urandom);
        add_push(4'hF, 4'h0, 1'b1, $urandom);
        repeat (66) add_push(4'hF, 4'($urandom), 1'b0, $urandom);
        repeat (68) add_pop();
        wait_drained();

        // capacity lowered below current fill
        n_settings++;
        write_reg(CFG_CHAT_TYPE, 7'h05);
        write_reg(CFG_HIGH_PRIO, 7'h0F);
        write_reg(CFG_CONTROL_CAP, 7'd64);
        write_reg(CFG_ALARM_CAP, 7'd64);
        write_reg(CFG_NORMAL_CAP, 7'd64);
        add_push(4'h5, 4'hF, 1'b1, $urandom);
        add_push(4'h5, 4'hE, 1'b1, $urandom);
        repeat (12) add_push(4'h5, 4'($urandom), 1'b0, $urandom);
        wait_drained();
        n_settings++;
        write_reg(CFG_NORMAL_CAP, 7'd4);
        add_push(4'h5, 4'h3, 1'b0, $urandom);
        add_push(4'h5, 4'h3, 1'b0, $urandom);
        repeat (12) add_pop();
        add_push(4'h5, 4'h3, 1'b0, $urandom);
        add_push(4'h5, 4'h3, 1'b0, $urandom);
        repeat (4) add_pop();
        wait_drained();

        // random settings and traffic
        for (int ph = 0; ph < 6; ph++)
        begin
            n_settings++;
            write_reg(CFG_CHAT_TYPE, 7'($urandom));
            case ($urandom_range(0, 2))
                0: write_reg(CFG_HIGH_PRIO, 7'h00);
                1: write_reg(CFG_HIGH_PRIO, 7'h0F);
                default: write_reg(CFG_HIGH_PRIO, 7'($urandom));
            endcase
            write_reg(CFG_CONTROL_CAP, pick_cap());
            write_reg(CFG_ALARM_CAP, pick_cap());
            write_reg(CFG_NORMAL_CAP, pick_cap());
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_UNUSED_LO, 7'($urandom));
            repeat (4) add_random(17, $urandom_range(30, 80), $urandom_range(50, 90));
            if (ph == 2)
                pressure_go = 1'b1;
            wait_drained();
        end

        repeat (10) @(negedge clk);
        $display("Covered %0d requests: %0d pushes (%0d rejected), %0d pops (%0d empty)",
                 n_push + n_pop, n_push, n_reject, n_pop, n_empty);
        $display("Served control %0d, alarm %0d, normal %0d over %0d settings, %0d reg writes",
                 n_served[LANE_CONTROL], n_served[LANE_ALARM], n_served[LANE_NORMAL],
                 n_settings, reg_writes);
        if (fail_count == 0 && rsp_expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
